FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/lta_pkg.sv
// ----------------------------------------------------------------------------
// lta_pkg
// Types and constants of the light threshold lamp and alarm controller.
// ----------------------------------------------------------------------------
package lta_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int COUNT_BITS  = 16;
   localparam int PERIOD_BITS = 16;
   localparam int DELTA_BITS  = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = {COUNT_BITS{1'b1}};
   localparam logic [SAMPLE_BITS-1:0] THRESH_MAX    = 12'd4095;
   localparam logic [SAMPLE_BITS-1:0] THRESH_RESET  = 12'd150;
   localparam logic [PERIOD_BITS-1:0] SAMPLE_PERIOD_RESET = 16'd100;
   localparam logic [PERIOD_BITS-1:0] BLINK_PERIOD_RESET  = 16'd250;

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_MODE        = 3'd1,
      OP_LAMP        = 3'd2,
      OP_MANUAL      = 3'd3,
      OP_AUTO_ALARM  = 3'd4,
      OP_ADJUST      = 3'd5
   } op_type;

   typedef enum logic {
      REG_SAMPLE_PERIOD = 1'b0,
      REG_BLINK_PERIOD  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [2:0]                    op;
      logic [SAMPLE_BITS-1:0]        adc_sample;
      logic signed [DELTA_BITS-1:0]  delta;
   } req_type;

   typedef struct packed {
      logic                   led_on;
      logic                   alarm_out;
      logic [SAMPLE_BITS-1:0] light_level;
      logic [SAMPLE_BITS-1:0] threshold_now;
      logic                   auto_mode_on;
      logic                   alarm_manual_on;
      logic                   alarm_auto_on;
      logic                   alarm_active;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] level;
      logic [SAMPLE_BITS-1:0] threshold;
      logic                   auto_flag;
      logic                   lamp_flag;
      logic                   manual_alarm;
      logic                   auto_alarm;
      logic                   alarm_flag;
      logic                   blink_phase;
      logic [COUNT_BITS-1:0]  sample_count;
      logic [COUNT_BITS-1:0]  blink_count;
   } state_type;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] sample_period;
      logic [PERIOD_BITS-1:0] blink_period;
   } cfg_type;

endpackage

FILE: hw/rtl/lta_csr.sv
// ----------------------------------------------------------------------------
// lta_csr
// Register file for the sample and blink periods behind an APB-style port.
// ----------------------------------------------------------------------------
module lta_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lta_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [lta_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [lta_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output lta_pkg::cfg_type                    cfg
);
   import lta_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type sel;
   logic          wr_en;

   // Registers sit on 32-bit word boundaries; the low address bits are ignored.
   assign sel    = reg_index_type'(paddr[2]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            REG_SAMPLE_PERIOD: cfg_in.sample_period = pwdata[PERIOD_BITS-1:0];
            REG_BLINK_PERIOD:  cfg_in.blink_period  = pwdata[PERIOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_SAMPLE_PERIOD:
            prdata = {{(CSR_DATA_BITS-PERIOD_BITS){1'b0}}, cfg_ff.sample_period};
         REG_BLINK_PERIOD:
            prdata = {{(CSR_DATA_BITS-PERIOD_BITS){1'b0}}, cfg_ff.blink_period};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period <= SAMPLE_PERIOD_RESET;
         cfg_ff.blink_period  <= BLINK_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/lta_update.sv
// ----------------------------------------------------------------------------
// lta_update
// Next-state logic: applies one event to the controller state.
// ----------------------------------------------------------------------------
module lta_update (
   input  lta_pkg::state_type cur,
   input  lta_pkg::req_type   item,
   input  lta_pkg::cfg_type   cfg,
   output lta_pkg::state_type nxt
);
   import lta_pkg::*;

   logic [COUNT_BITS-1:0]  sc_inc;
   logic [COUNT_BITS-1:0]  bc_inc;
   logic                   sample_hit;
   logic                   blink_hit;
   logic [SAMPLE_BITS-1:0] tick_level;
   logic                   tick_lamp;
   logic                   tick_alarm;
   logic signed [SAMPLE_BITS+DELTA_BITS-11:0] thr_sum;
   logic [SAMPLE_BITS-1:0] thr_adj;

   // Elapsed counters saturate rather than wrap.
   assign sc_inc = (cur.sample_count == COUNT_MAX) ? cur.sample_count
                                                   : cur.sample_count + 1'b1;
   assign bc_inc = (cur.blink_count == COUNT_MAX) ? cur.blink_count
                                                  : cur.blink_count + 1'b1;
   assign sample_hit = sc_inc >= cfg.sample_period;
   assign blink_hit  = bc_inc >= cfg.blink_period;

   assign tick_level = sample_hit ? item.adc_sample : cur.level;
   assign tick_lamp  = (sample_hit && cur.auto_flag) ? (tick_level < cur.threshold)
                                                     : cur.lamp_flag;
   assign tick_alarm = cur.manual_alarm || (cur.auto_alarm && (tick_level > cur.threshold));

   // Threshold adjust in 18-bit signed arithmetic, then clamped to the 12-bit range.
   assign thr_sum = $signed({6'b0, cur.threshold})
                  + $signed({{2{item.delta[DELTA_BITS-1]}}, item.delta});

   always_comb begin
      if (thr_sum[SAMPLE_BITS+DELTA_BITS-11]) begin
         thr_adj = '0;
      end else if (thr_sum > $signed({6'b0, THRESH_MAX})) begin
         thr_adj = THRESH_MAX;
      end else begin
         thr_adj = thr_sum[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      nxt = cur;
      case (item.op)
         OP_TICK: begin
            nxt.sample_count = sample_hit ? '0 : sc_inc;
            nxt.level        = tick_level;
            nxt.lamp_flag    = tick_lamp;
            nxt.alarm_flag   = tick_alarm;
            if (!tick_alarm) begin
               nxt.blink_phase = 1'b0;
               nxt.blink_count = bc_inc;
            end else if (blink_hit) begin
               nxt.blink_phase = ~cur.blink_phase;
               nxt.blink_count = '0;
            end else begin
               nxt.blink_count = bc_inc;
            end
         end
         OP_MODE: begin
            nxt.auto_flag = ~cur.auto_flag;
            if (!cur.auto_flag) begin
               nxt.lamp_flag = cur.level < cur.threshold;
            end
         end
         OP_LAMP: begin
            if (!cur.auto_flag) begin
               nxt.lamp_flag = ~cur.lamp_flag;
            end
         end
         OP_MANUAL: begin
            nxt.manual_alarm = ~cur.manual_alarm;
            // Switching the manual alarm off silences the output at once.
            if (cur.manual_alarm) begin
               nxt.blink_phase = 1'b0;
            end
         end
         OP_AUTO_ALARM: begin
            nxt.auto_alarm = ~cur.auto_alarm;
         end
         OP_ADJUST: begin
            nxt.threshold = thr_adj;
            if (cur.auto_flag) begin
               nxt.lamp_flag = cur.level < thr_adj;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/light_threshold_lamp_alarm_core.sv
// ----------------------------------------------------------------------------
// light_threshold_lamp_alarm_core
// Lamp and alarm controller driven by tick and user events.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the req channel (req_valid, req_stall, req_data) and each
// produces exactly one status result on the rsp channel. A transfer happens
// at a rising edge where valid is high and stall is low.
// A transferred event lands in the input register; when it advances it is
// applied to the controller state and its result goes to the result register.
// The state update is a single pass of logic, so one event per cycle is
// sustained while the receiver does not stall; an event may follow in the
// very next cycle and sees the state left by its predecessor.
// When the receiver stalls, the result register holds; one more event is
// still taken into the input register, after which req_stall rises.
// The csr port holds the sample and blink periods (byte addresses 0 and 4),
// written by the user only while idle (not enforced); pready is always high.
// Synchronous reset restores the periods to 100 and 250 ticks, the threshold
// to 150, auto mode and auto alarm on, and empties both registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module light_threshold_lamp_alarm_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lta_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lta_pkg::rsp_type                    rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lta_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [lta_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [lta_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import lta_pkg::*;

   cfg_type   cfg;
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      accept;
   logic      advance;

   lta_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lta_update u_update (
      .cur  (state_ff),
      .item (in_data_ff),
      .cfg  (cfg),
      .nxt  (state_in)
   );

   // The held event moves on whenever the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_data_in.led_on          = state_in.lamp_flag;
      rsp_data_in.alarm_out       = state_in.blink_phase;
      rsp_data_in.light_level     = state_in.level;
      rsp_data_in.threshold_now   = state_in.threshold;
      rsp_data_in.auto_mode_on    = state_in.auto_flag;
      rsp_data_in.alarm_manual_on = state_in.manual_alarm;
      rsp_data_in.alarm_auto_on   = state_in.auto_alarm;
      rsp_data_in.alarm_active    = state_in.alarm_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.level        <= '0;
         state_ff.threshold    <= THRESH_RESET;
         state_ff.auto_flag    <= 1'b1;
         state_ff.lamp_flag    <= 1'b0;
         state_ff.manual_alarm <= 1'b0;
         state_ff.auto_alarm   <= 1'b1;
         state_ff.alarm_flag   <= 1'b0;
         state_ff.blink_phase  <= 1'b0;
         state_ff.sample_count <= '0;
         state_ff.blink_count  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CHK_IMPLY(a_phase_needs_alarm, state_ff.blink_phase, state_ff.alarm_flag,
      "alarm output on while alarm is inactive")
   `CHK_IMPLY(a_stall_needs_item, req_stall, in_valid_ff && rsp_valid_ff && rsp_stall,
      "input stalled without a held event behind a stalled result")
   `CHK_NEXT(a_advance_fills_rsp, advance, rsp_valid_ff,
      "processed event did not reach the result register")

endmodule
